FILE: src/lrc_pkg.sv
// shared types, constants and tail math for the led ring comet frame block
`default_nettype none
package lrc_pkg;

    // field widths
    localparam int MODE_W     = 2;
    localparam int PERIOD_W   = 16;
    localparam int RING_W     = 7;
    localparam int TIME_W     = 32;
    localparam int IDX_W      = 6;
    localparam int LEVEL_W    = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int TAIL_W     = 3;

    // divider steps, one quotient bit per cycle
    localparam int DIV_STEPS = TIME_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RING   = 2'd2;

    // program modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RED  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLUE = 2'd2;

    // reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd750;
    localparam logic [RING_W-1:0]   RING_RESET   = 7'd16;

    // tail lengths and levels
    localparam logic [TAIL_W-1:0]  RED_TAIL   = 3'd4;
    localparam logic [TAIL_W-1:0]  BLUE_TAIL  = 3'd3;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

    // controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic div_step;
        logic mul_load;
        logic emit;
    } lrc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic frame_ok;
        logic out_free;
        logic led_last;
    } lrc_status_t;

    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
    } tail_hit_t;

    // floor(255*a^2 / (2*T^2)) for the two tail lengths
    function automatic logic [LEVEL_W-1:0] tail_level(input logic blue,
                                                      input logic [TAIL_W-1:0] a);
        logic [LEVEL_W-1:0] lv;
        lv = '0;
        if (blue)
        begin
            case (a)
                3'd2:    lv = 8'd56;
                3'd1:    lv = 8'd14;
                default: lv = 8'd0;
            endcase
        end
        else
        begin
            case (a)
                3'd3:    lv = 8'd71;
                3'd2:    lv = 8'd31;
                3'd1:    lv = 8'd7;
                default: lv = 8'd0;
            endcase
        end
        return lv;
    endfunction

    // wrapped distance from one head to one led and the resulting write
    function automatic tail_hit_t tail_check(input logic [RING_W:0]   head,
                                             input logic [RING_W-1:0] led,
                                             input logic [RING_W-1:0] n,
                                             input logic              blue);
        logic signed [RING_W+2:0] d;
        logic signed [RING_W+2:0] dw;
        logic [RING_W+2:0]        ad;
        logic [RING_W+2:0]        adw;
        logic [TAIL_W-1:0]        tl;
        tail_hit_t                r;
        d  = $signed({2'b00, head}) - $signed({3'b000, led});
        ad = d[RING_W+2] ? (RING_W+3)'(-d) : (RING_W+3)'(d);
        // wrap once when more than half a ring away
        if (ad > {4'b0000, n[RING_W-1:1]})
        begin
            dw = d[RING_W+2] ? d + $signed({3'b000, n}) : d - $signed({3'b000, n});
        end
        else
        begin
            dw = d;
        end
        adw = dw[RING_W+2] ? (RING_W+3)'(-dw) : (RING_W+3)'(dw);
        tl  = blue ? BLUE_TAIL : RED_TAIL;
        r.hit = (adw <= {{(RING_W){1'b0}}, tl});
        if (dw == '0)
        begin
            r.level = FULL_LEVEL;
        end
        else if (dw[RING_W+2])
        begin
            r.level = '0;
        end
        else
        begin
            r.level = tail_level(blue, tl - adw[TAIL_W-1:0]);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/lrc_datapath.sv
// config registers, shared bit-serial divider, led walk and output register
`default_nettype none
module lrc_datapath #(
    parameter int MAX_LEDS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [lrc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [lrc_pkg::CFG_W-1:0]         cfg_data,
    input  wire logic [lrc_pkg::TIME_W-1:0]        time_ms,
    input  wire lrc_pkg::lrc_cmd_t                 cmd,
    output lrc_pkg::lrc_status_t                   status,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [lrc_pkg::IDX_W-1:0]              led_index,
    output logic                                   write_pixel,
    output logic [lrc_pkg::LEVEL_W-1:0]            red,
    output logic [lrc_pkg::LEVEL_W-1:0]            green,
    output logic [lrc_pkg::LEVEL_W-1:0]            blue,
    output logic                                   last_led
);

    localparam int RW       = lrc_pkg::RING_W;
    localparam int PW       = lrc_pkg::PERIOD_W;
    localparam int TW       = lrc_pkg::TIME_W;
    localparam int LW       = lrc_pkg::LEVEL_W;
    localparam int RING_MAX = (2 ** RW) - 1;
    localparam int RING_CAP = (MAX_LEDS > RING_MAX) ? RING_MAX : MAX_LEDS;

    // config registers
    logic [lrc_pkg::MODE_W-1:0] mode_reg;
    logic [PW-1:0]              period_reg;
    logic [RW-1:0]              ring_reg;

    // frame registers
    logic [RW-1:0] n_reg;
    logic          blue_mode_reg;
    logic [RW-1:0] idx_reg;
    logic [PW:0]   rem_reg;
    logic [TW-1:0] dvd_reg;

    // output register
    logic          out_valid_reg;
    logic [lrc_pkg::IDX_W-1:0] led_index_reg;
    logic          write_pixel_reg;
    logic [LW-1:0] red_reg;
    logic [LW-1:0] blue_out_reg;
    logic          last_led_reg;

    logic [PW-1:0]    p_eff;
    logic [RW-1:0]    n_eff;
    logic [PW:0]      rem_shift;
    logic             rem_ge;
    logic [PW:0]      rem_diff;
    logic [PW+RW-1:0] prod;
    logic [RW:0]      head;
    logic [RW:0]      head2;
    lrc_pkg::tail_hit_t hit1;
    lrc_pkg::tail_hit_t hit2;
    logic             wr;
    logic [LW-1:0]    level;
    logic             mode_ok;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= lrc_pkg::MODE_NONE;
            period_reg <= lrc_pkg::PERIOD_RESET;
            ring_reg   <= lrc_pkg::RING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                lrc_pkg::REG_MODE:   mode_reg   <= cfg_data[lrc_pkg::MODE_W-1:0];
                lrc_pkg::REG_PERIOD: period_reg <= cfg_data[PW-1:0];
                lrc_pkg::REG_RING:   ring_reg   <= cfg_data[RW-1:0];
                default:             ;
            endcase
        end
    end

    // effective period and ring size
    assign p_eff   = (period_reg == '0) ? PW'(1) : period_reg;
    assign n_eff   = (ring_reg > RW'(RING_CAP)) ? RW'(RING_CAP) : ring_reg;
    assign mode_ok = (mode_reg == lrc_pkg::MODE_RED) || (mode_reg == lrc_pkg::MODE_BLUE);

    // restoring divide step
    assign rem_shift = {rem_reg[PW-1:0], dvd_reg[TW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, p_eff});
    assign rem_diff  = rem_shift - {1'b0, p_eff};
    assign prod      = rem_reg[PW-1:0] * n_reg;

    // divider and frame state
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dvd_reg       <= time_ms;
            rem_reg       <= '0;
            n_reg         <= n_eff;
            blue_mode_reg <= (mode_reg == lrc_pkg::MODE_BLUE);
            idx_reg       <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem_diff : rem_shift;
            dvd_reg <= {dvd_reg[TW-2:0], rem_ge};
        end
        else if (cmd.mul_load)
        begin
            dvd_reg <= {{(TW-PW-RW){1'b0}}, prod};
            rem_reg <= '0;
        end
        else if (cmd.emit)
        begin
            idx_reg <= idx_reg + RW'(1);
        end
    end

    // pixel for the current led, second tail wins
    assign head  = {1'b0, dvd_reg[RW-1:0]};
    assign head2 = head + {2'b00, n_reg[RW-1:1]};
    assign hit1  = lrc_pkg::tail_check(head, idx_reg, n_reg, blue_mode_reg);
    assign hit2  = lrc_pkg::tail_check(head2, idx_reg, n_reg, blue_mode_reg);

    always_comb
    begin
        wr    = hit1.hit;
        level = hit1.hit ? hit1.level : '0;
        if (blue_mode_reg && hit2.hit)
        begin
            wr    = 1'b1;
            level = hit2.level;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            led_index_reg   <= idx_reg[lrc_pkg::IDX_W-1:0];
            write_pixel_reg <= wr;
            red_reg         <= blue_mode_reg ? '0 : level;
            blue_out_reg    <= blue_mode_reg ? level : '0;
            last_led_reg    <= status.led_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_index   = led_index_reg;
    assign write_pixel = write_pixel_reg;
    assign red         = red_reg;
    assign green       = '0;
    assign blue        = blue_out_reg;
    assign last_led    = last_led_reg;

    // status back to the controller
    assign status.frame_ok = mode_ok && (n_eff != '0);
    assign status.out_free = !out_valid_reg || out_ready;
    assign status.led_last = (idx_reg == n_reg - RW'(1));

    // head quotient always lands on the ring
    a_head_on_ring: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (dvd_reg < {{(TW-RW){1'b0}}, n_reg}))
        else $error("head position beyond ring size");

    // time remainder stays below the period
    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_load |-> (rem_reg < {1'b0, p_eff}))
        else $error("remainder not below period");

    // no result overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded over pending result");

endmodule
`default_nettype wire

FILE: src/lrc_ctrl.sv
// frame sequencer: accept, divide time by period, scale, divide again, walk leds
`default_nettype none
module lrc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lrc_pkg::lrc_status_t status,
    output lrc_pkg::lrc_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_T,
        ST_SCALE,
        ST_DIV_H,
        ST_EMIT
    } state_t;

    localparam logic [lrc_pkg::STEP_W-1:0] STEP_LAST =
        lrc_pkg::STEP_W'(lrc_pkg::DIV_STEPS - 1);

    state_t                       state_reg;
    logic [lrc_pkg::STEP_W-1:0]   step_reg;

    // commands decoded from state
    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.div_step = (state_reg == ST_DIV_T) || (state_reg == ST_DIV_H);
    assign cmd.mul_load = (state_reg == ST_SCALE);
    assign cmd.emit     = (state_reg == ST_EMIT) && status.out_free;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (in_valid && status.frame_ok)
                    begin
                        state_reg <= ST_DIV_T;
                    end
                end
                ST_DIV_T:
                begin
                    step_reg <= step_reg + lrc_pkg::STEP_W'(1);
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV_H;
                end
                ST_DIV_H:
                begin
                    step_reg <= step_reg + lrc_pkg::STEP_W'(1);
                    if (step_reg == STEP_LAST)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (cmd.emit && status.led_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // time divide ends after its full step count
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_T && step_reg == STEP_LAST) |=> (state_reg == ST_SCALE))
        else $error("time divide did not finish");

    // last led returns to idle
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && status.led_last) |=> (state_reg == ST_IDLE))
        else $error("frame did not end on last led");

    // a request with nothing to draw is dropped
    a_empty_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !status.frame_ok) |=> (state_reg == ST_IDLE))
        else $error("empty frame started work");

endmodule
`default_nettype wire

FILE: src/led_ring_comet_tail_frame.sv
// top level of the led ring comet tail frame generator
//
//  port group   dir  handshake          payload
//  in           in   in_valid/in_ready  time_ms
//  out          out  out_valid/out_ready led_index write_pixel red green blue last_led
//  cfg          in   cfg_we             cfg_addr cfg_data
//
//  a request is accepted, then goes twice through one shared bit-serial divider
//  (time mod period, then scaled remainder over period), then one led per cycle
//  that the output register can take
//  an empty mode or zero ring size drops the request
//  a stalled output holds the led walk; reset restores the config defaults
`default_nettype none
module led_ring_comet_tail_frame #(
    parameter int MAX_LEDS = 64
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [lrc_pkg::TIME_W-1:0]     time_ms,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lrc_pkg::IDX_W-1:0]           led_index,
    output logic                                write_pixel,
    output logic [lrc_pkg::LEVEL_W-1:0]         red,
    output logic [lrc_pkg::LEVEL_W-1:0]         green,
    output logic [lrc_pkg::LEVEL_W-1:0]         blue,
    output logic                                last_led,
    input  wire logic                           cfg_we,
    input  wire logic [lrc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [lrc_pkg::CFG_W-1:0]      cfg_data
);

    lrc_pkg::lrc_cmd_t    cmd;
    lrc_pkg::lrc_status_t status;

    // sequencer
    lrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    lrc_datapath #(
        .MAX_LEDS (MAX_LEDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .time_ms     (time_ms),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .led_index   (led_index),
        .write_pixel (write_pixel),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .last_led    (last_led)
    );

endmodule
`default_nettype wire

FILE: test/comet_frame_checker.sv
// checker that predicts and compares the led writes of each comet frame request
`default_nettype none
module comet_frame_checker
    import lrc_pkg::*;
#(
    parameter int MAX_LEDS = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [TIME_W-1:0]     time_ms,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [IDX_W-1:0]      led_index,
    input  wire logic                  write_pixel,
    input  wire logic [LEVEL_W-1:0]    red,
    input  wire logic [LEVEL_W-1:0]    green,
    input  wire logic [LEVEL_W-1:0]    blue,
    input  wire logic                  last_led,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_W-1:0]      cfg_data,
    output int                         mismatch_count,
    output int                         writes_pending
);

    typedef struct packed {
        logic [IDX_W-1:0]   led;
        logic               wr;
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
        logic               last;
    } led_write_t;

    // expected led writes, oldest first
    led_write_t writes_due[$];
    led_write_t due_head;
    int         mismatches = 0;

    // mirrored registers
    logic [MODE_W-1:0]   mode_q;
    logic [PERIOD_W-1:0] period_q;
    logic [RING_W-1:0]   ring_q;

    initial
    begin
        mismatch_count = 0;
        writes_pending = 0;
    end

    // level one comet tail gives one led, returns whether the led is written
    function automatic bit comet_level(int led, int head, int n, int tl, output int lvl);
        int d;
        int ad;
        int a;
        d  = head - led;
        ad = (d < 0) ? -d : d;
        // single wrap when more than half a ring apart
        if (ad > n / 2)
        begin
            d = (d > 0) ? d - n : d + n;
        end
        ad  = (d < 0) ? -d : d;
        lvl = 0;
        if (ad > tl)
            return 1'b0;
        a = tl - ad;
        if (d == 0)
            lvl = int'(FULL_LEVEL);
        else if (d > 0)
            lvl = (int'(FULL_LEVEL) * a * a) / (2 * tl * tl);
        return 1'b1;
    endfunction

    // queue the led writes that one time stamp produces
    function automatic void predict_frame(logic [TIME_W-1:0] t);
        longint unsigned p;
        longint unsigned rem;
        int              n;
        int              head;
        int              head2;
        int              tl;
        int              lvl;
        int              lvl2;
        int              i;
        bit              hit;
        bit              police;
        led_write_t      w;
        if (mode_q != MODE_RED && mode_q != MODE_BLUE)
            return;
        n = (ring_q > MAX_LEDS) ? MAX_LEDS : int'(ring_q);
        if (n == 0)
            return;
        p      = (period_q == '0) ? 64'd1 : 64'(period_q);
        rem    = 64'(t) % p;
        head   = int'((rem * 64'(n)) / p);
        police = (mode_q == MODE_BLUE);
        tl     = police ? int'(BLUE_TAIL) : int'(RED_TAIL);
        // second head is not reduced onto the ring
        head2  = head + n / 2;
        for (i = 0; i < n; i++)
        begin
            hit = comet_level(i, head, n, tl, lvl);
            // second tail overrides the first
            if (police && comet_level(i, head2, n, tl, lvl2))
            begin
                hit = 1'b1;
                lvl = lvl2;
            end
            if (!hit)
                lvl = 0;
            w.led  = IDX_W'(i);
            w.wr   = hit;
            w.r    = police ? '0 : LEVEL_W'(lvl);
            w.g    = '0;
            w.b    = police ? LEVEL_W'(lvl) : '0;
            w.last = (i == n - 1);
            writes_due.push_back(w);
        end
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: led write %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // watch config, request and result channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q   <= MODE_NONE;
            period_q <= PERIOD_RESET;
            ring_q   <= RING_RESET;
            writes_due.delete();
            writes_pending <= 0;
        end
        else
        begin
            // compare a finished led write with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (writes_due.size() == 0)
                begin
                    $display("%0t: unexpected led write, expected none, actual led %0d wr %0b",
                             $time, led_index, write_pixel);
                    $display("%0t:   actual rgb %0d %0d %0d last %0b",
                             $time, red, green, blue, last_led);
                    mismatches++;
                end
                else
                begin
                    due_head = writes_due.pop_front();
                    check_field("led_index", int'(due_head.led), int'(led_index));
                    check_field("write_pixel", int'(due_head.wr), int'(write_pixel));
                    check_field("red", int'(due_head.r), int'(red));
                    check_field("green", int'(due_head.g), int'(green));
                    check_field("blue", int'(due_head.b), int'(blue));
                    check_field("last_led", int'(due_head.last), int'(last_led));
                end
            end
            // new frame request
            if (in_valid && in_ready)
                predict_frame(time_ms);
            // register writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
                    REG_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
                    REG_RING:   ring_q   <= cfg_data[RING_W-1:0];
                    default:    ;
                endcase
            end
            writes_pending <= writes_due.size();
        end
        mismatch_count <= mismatches;
    end

endmodule
`default_nettype wire

FILE: test/led_ring_comet_tail_frame_tb.sv
// top of the led ring comet tail frame testbench: stimulus, checker hookup and verdict
`default_nettype none
module led_ring_comet_tail_frame_tb;
    import lrc_pkg::*;

    localparam int                MAX_LEDS        = 64;
    localparam int                ITEMS_PER_PHASE = 60;
    localparam int                DRAIN_CYCLES    = 200;
    localparam int                WATCHDOG_LIMIT  = 20000;
    localparam logic [MODE_W-1:0] MODE_UNUSED     = 2'd3;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic [TIME_W-1:0]     time_ms     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [IDX_W-1:0]      led_index;
    logic                  write_pixel;
    logic [LEVEL_W-1:0]    red;
    logic [LEVEL_W-1:0]    green;
    logic [LEVEL_W-1:0]    blue;
    logic                  last_led;
    logic                  cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = REG_MODE;
    logic [CFG_W-1:0]      cfg_data    = '0;

    int mismatch_count;
    int writes_pending;
    int tx_idle_pct  = 23;
    int rx_idle_pct  = 80;
    int stall_cycles = 0;

    led_ring_comet_tail_frame #(
        .MAX_LEDS(MAX_LEDS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .time_ms    (time_ms),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .led_index  (led_index),
        .write_pixel(write_pixel),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .last_led   (last_led),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data)
    );

    comet_frame_checker #(
        .MAX_LEDS(MAX_LEDS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .time_ms       (time_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .led_index     (led_index),
        .write_pixel   (write_pixel),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .last_led      (last_led),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .writes_pending(writes_pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[led_ring_comet_tail_frame] ERROR");
            $finish;
        end
    end

    // write all three registers back to back
    task automatic set_config(logic [CFG_W-1:0] m, logic [CFG_W-1:0] p, logic [CFG_W-1:0] r);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_MODE;
        cfg_data <= m;
        @(posedge clk);
        cfg_addr <= REG_PERIOD;
        cfg_data <= p;
        @(posedge clk);
        cfg_addr <= REG_RING;
        cfg_data <= r;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // one frame request with a random gap in front
    task automatic send_time(logic [TIME_W-1:0] t);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        time_ms  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // let every expected write drain, then give dropped requests time to clear
    task automatic wait_idle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (writes_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int               phase;
        int               counted;
        int               burst;
        int               k;
        int               pv;
        logic [CFG_W-1:0] m;
        logic [CFG_W-1:0] p;
        logic [CFG_W-1:0] r;
        logic [TIME_W-1:0] t;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers at reset select no program
        send_time('0);
        wait_idle();

        // red tail, default period and ring, head at both ends of the period
        set_config(CFG_W'(MODE_RED), 16'd750, 16'd16);
        send_time(32'd0);
        send_time(32'd749);
        send_time(32'd750);
        send_time(32'd375);
        send_time(32'hFFFF_FFFF);
        send_time(32'd46);
        send_time(32'd47);
        wait_idle();

        // blue double tail
        set_config(CFG_W'(MODE_BLUE), 16'd750, 16'd16);
        send_time(32'd0);
        send_time(32'd374);
        send_time(32'd749);
        send_time(32'hFFFF_FFFF);
        wait_idle();

        // unused mode gives no writes
        set_config(CFG_W'(MODE_UNUSED), 16'd750, 16'd16);
        send_time(32'd5);
        wait_idle();

        // zero period keeps the head at led zero, full ring
        set_config(CFG_W'(MODE_RED), 16'd0, 16'd64);
        send_time(32'd12345);
        wait_idle();

        // largest period, ring size above the maximum saturates
        set_config(CFG_W'(MODE_BLUE), 16'hFFFF, 16'd127);
        send_time(32'd65534);
        send_time(32'd32767);
        send_time(32'hFFFF_FFFF);
        wait_idle();

        // tiny rings, one of them with the second head running past the end
        set_config(CFG_W'(MODE_BLUE), 16'd2, 16'd1);
        send_time(32'd3);
        wait_idle();
        set_config(CFG_W'(MODE_BLUE), 16'd2, 16'd2);
        send_time(32'd1);
        wait_idle();
        set_config(CFG_W'(MODE_RED), 16'd3, 16'd3);
        send_time(32'd2);
        wait_idle();

        // empty ring and explicit mode none
        set_config(CFG_W'(MODE_RED), 16'd5, 16'd0);
        send_time(32'd7);
        wait_idle();
        set_config(CFG_W'(MODE_NONE), 16'd5, 16'd5);
        send_time(32'd9);
        wait_idle();

        // random settings and time stamps over three idle profiles
        for (phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 80 : 0;
            rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 23 : 0;
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: m = CFG_W'(MODE_RED);
                    4, 5, 6, 7: m = CFG_W'(MODE_BLUE);
                    8:          m = CFG_W'(MODE_NONE);
                    default:    m = CFG_W'(MODE_UNUSED);
                endcase
                // unused upper data bits
                if ($urandom_range(1))
                    m[CFG_W-1:MODE_W] = (CFG_W-MODE_W)'($urandom >> 3);
                case ($urandom_range(9))
                    0:          p = '0;
                    1:          p = 16'd1;
                    2:          p = 16'hFFFF;
                    3, 4, 5:    p = CFG_W'($urandom_range(40, 2));
                    default:    p = CFG_W'($urandom);
                endcase
                case ($urandom_range(11))
                    0:          r = '0;
                    1:          r = CFG_W'($urandom_range(127, 65));
                    2:          r = CFG_W'(MAX_LEDS);
                    default:    r = CFG_W'($urandom_range(MAX_LEDS, 1));
                endcase
                if ($urandom_range(1))
                    r[CFG_W-1:RING_W] = (CFG_W-RING_W)'($urandom >> 5);
                set_config(m, p, r);
                pv    = int'(p[PERIOD_W-1:0]);
                burst = int'($urandom_range(14, 4));
                for (k = 0; k < burst; k++)
                begin
                    case ($urandom_range(9))
                        0:       t = '0;
                        1:       t = '1;
                        2, 3, 4: t = $urandom_range(3 * pv);
                        default: t = $urandom;
                    endcase
                    send_time(t);
                end
                wait_idle();
                counted += burst;
            end
        end

        if (mismatch_count == 0 && writes_pending == 0)
            $display("[led_ring_comet_tail_frame] OK");
        else
            $display("[led_ring_comet_tail_frame] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
